// File: rtl/core/tcprto_pkg.sv
// tcprto_pkg: shared types and constants for the rto estimator core
// holds field widths, register indexes and register reset values
// no dependencies; used by tcp_rto_estimator_core and tcprto_checker
package tcprto_pkg;

  // field widths
  localparam int PRIM_W   = 25;
  localparam int FALL_W   = 24;
  localparam int TICK_W   = 24;
  localparam int STATE_W  = 32;
  localparam int SHIFT_W  = 3;

  // packed stream widths, padded to whole bytes
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 88;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA_SHIFT = 2'd0,
    REG_BETA_SHIFT  = 2'd1,
    REG_CLOCK_GRAN  = 2'd2,
    REG_RTO_LIMIT   = 2'd3
  } cfg_reg_t;

  // register reset values
  localparam logic [SHIFT_W-1:0] ALPHA_SHIFT_RST = 3'd3;
  localparam logic [SHIFT_W-1:0] BETA_SHIFT_RST  = 3'd2;
  localparam logic [TICK_W-1:0]  CLOCK_GRAN_RST  = 24'd1;
  localparam logic [TICK_W-1:0]  RTO_LIMIT_RST   = 24'd60;

  // initial smoothed rtt and deviation in whole ticks
  localparam int STATE_INIT_TICKS = 3;

endpackage

// File: rtl/core/tcp_rto_estimator_core.sv
// tcp_rto_estimator_core: retransmission timeout estimator, top level
// three stage stream pipeline: input register, state update, rto register
// depends on tcprto_pkg
//
// a sample passes the input register, srtt_r/rttvar_r and then rto_r
// throughput: one rtt sample per cycle while out_tready keeps up; the srtt and
//   rttvar loop has no extra register, so back-to-back samples see fresh state
// reset (rst_n low, synchronous): pipeline emptied, registers to defaults,
//   smoothed rtt and deviation to three ticks
module tcp_rto_estimator_core #(
  parameter int TIME_BITS = 24,
  parameter int FRAC_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,

  // input stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // [24:0] primary_sample (signed), [48:25] fallback_sample, [55:49] zero
  input  logic [tcprto_pkg::IN_DATA_W-1:0]       in_tdata,

  // result stream
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // [23:0] rto_value, [55:24] smoothed_rtt, [87:56] rtt_deviation
  output logic [tcprto_pkg::OUT_DATA_W-1:0]      out_tdata,

  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tcprto_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcprto_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int TW = tcprto_pkg::TICK_W;
  localparam int SW = tcprto_pkg::STATE_W;

  // sample in fixed point before saturation; at least 33 bits so the
  // 32 bit saturation compare is meaningful
  localparam int MW = (TW + FRAC_BITS > SW) ? TW + FRAC_BITS : SW + 1;
  // rto sum width: max of g (TW+FRAC) and 4*var (34), plus srtt, plus rounding
  localparam int RW = ((TW + FRAC_BITS > SW + 2) ? TW + FRAC_BITS : SW + 2) + 2;

  localparam logic [32:0]   TIME_MAX   = (33'(1) << TIME_BITS) - 33'(1);
  localparam logic [MW-1:0] SAT_M      = MW'(33'h0_FFFF_FFFF);
  localparam logic [RW-1:0] ROUND_UP   = RW'((64'(1) << FRAC_BITS) - 64'(1));
  localparam logic [SW-1:0] STATE_INIT =
    SW'(tcprto_pkg::STATE_INIT_TICKS) << FRAC_BITS;

  // move cur toward target by |target - cur| >> sh, truncating toward cur
  function automatic logic [SW-1:0] ewma(input logic [SW-1:0] cur,
                                         input logic [SW-1:0] target,
                                         input logic [tcprto_pkg::SHIFT_W-1:0] sh);
    logic [SW-1:0] diff;
    begin
      if (target >= cur) begin
        diff = (target - cur) >> sh;
        ewma = cur + diff;
      end else begin
        diff = (cur - target) >> sh;
        ewma = cur - diff;
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // configuration registers; always ready
  // ---------------------------------------------------------------------
  logic [tcprto_pkg::SHIFT_W-1:0] alpha_r;
  logic [tcprto_pkg::SHIFT_W-1:0] beta_r;
  logic [TW-1:0]                  gran_r;
  logic [TW-1:0]                  limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= tcprto_pkg::ALPHA_SHIFT_RST;
      beta_r  <= tcprto_pkg::BETA_SHIFT_RST;
      gran_r  <= tcprto_pkg::CLOCK_GRAN_RST;
      limit_r <= tcprto_pkg::RTO_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tcprto_pkg::cfg_reg_t'(cfg_index))
        tcprto_pkg::REG_ALPHA_SHIFT: alpha_r <= cfg_data[tcprto_pkg::SHIFT_W-1:0];
        tcprto_pkg::REG_BETA_SHIFT:  beta_r  <= cfg_data[tcprto_pkg::SHIFT_W-1:0];
        tcprto_pkg::REG_CLOCK_GRAN:  gran_r  <= cfg_data[TW-1:0];
        tcprto_pkg::REG_RTO_LIMIT:   limit_r <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // pipeline flow control: each stage moves when the one after it frees up
  // ---------------------------------------------------------------------
  logic in_v_r, mid_v_r, out_v_r;
  logic out_en, mid_en, in_en;

  assign out_en    = !out_v_r || out_tready;
  assign mid_en    = !mid_v_r || out_en;
  assign in_en     = !in_v_r  || mid_en;
  assign in_tready = in_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      mid_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_en)  in_v_r  <= in_tvalid;
      if (mid_en) mid_v_r <= in_v_r;
      if (out_en) out_v_r <= mid_v_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 0: input register
  // ---------------------------------------------------------------------
  logic [tcprto_pkg::PRIM_W-1:0] prim_r;
  logic [tcprto_pkg::FALL_W-1:0] fall_r;

  always_ff @(posedge clk) begin
    if (in_en && in_tvalid) begin
      prim_r <= in_tdata[tcprto_pkg::PRIM_W-1:0];
      fall_r <= in_tdata[tcprto_pkg::PRIM_W +: tcprto_pkg::FALL_W];
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: state update; srtt_r and rttvar_r double as the middle stage
  // ---------------------------------------------------------------------
  logic [TW-1:0] ticks_sel;
  logic [TW-1:0] ticks_c;
  logic [MW-1:0] m_wide;
  logic [SW-1:0] m_c;
  logic [SW-1:0] srtt_nxt;
  logic [SW-1:0] dev_c;
  logic [SW-1:0] rttvar_nxt;
  logic [SW-1:0] srtt_r;
  logic [SW-1:0] rttvar_r;

  always_comb begin
    // karn's rule: a negative primary sample is replaced by the fallback
    ticks_sel = prim_r[tcprto_pkg::PRIM_W-1] ? fall_r : prim_r[TW-1:0];
    // saturate to the tick range of the timer
    ticks_c   = (33'(ticks_sel) > TIME_MAX) ? TIME_MAX[TW-1:0] : ticks_sel;
    m_wide    = MW'(ticks_c) << FRAC_BITS;
    m_c       = (m_wide > SAT_M) ? '1 : m_wide[SW-1:0];
    srtt_nxt  = ewma(srtt_r, m_c, alpha_r);
    // deviation measured against the freshly updated average
    dev_c      = (srtt_nxt >= m_c) ? srtt_nxt - m_c : m_c - srtt_nxt;
    rttvar_nxt = ewma(rttvar_r, dev_c, beta_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srtt_r   <= STATE_INIT;
      rttvar_r <= STATE_INIT;
    end else if (mid_en && in_v_r) begin
      srtt_r   <= srtt_nxt;
      rttvar_r <= rttvar_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: rto = srtt + max(g, 4*rttvar), rounded up, clamped
  // ---------------------------------------------------------------------
  logic [RW-1:0] gran_fx;
  logic [RW-1:0] four_var;
  logic [RW-1:0] rto_sum;
  logic [RW-1:0] rto_ticks;
  logic [TW-1:0] rto_nxt;
  logic [TW-1:0] rto_r;
  logic [SW-1:0] srtt_out_r;
  logic [SW-1:0] rttvar_out_r;

  always_comb begin
    gran_fx   = RW'(gran_r) << FRAC_BITS;
    four_var  = RW'(rttvar_r) << 2;
    rto_sum   = RW'(srtt_r) + ((gran_fx > four_var) ? gran_fx : four_var);
    rto_ticks = (rto_sum + ROUND_UP) >> FRAC_BITS;
    rto_nxt   = (rto_ticks > RW'(limit_r)) ? limit_r : rto_ticks[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (out_en && mid_v_r) begin
      rto_r        <= rto_nxt;
      srtt_out_r   <= srtt_r;
      rttvar_out_r <= rttvar_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {rttvar_out_r, srtt_out_r, rto_r};

endmodule

// File: rtl/core/tcprto_checker.sv
// tcprto_checker: port-level assertions for tcp_rto_estimator_core
// bound to the top level below; depends on tcprto_pkg
module tcprto_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [tcprto_pkg::OUT_DATA_W-1:0]    out_tdata,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stalled result keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // with no result waiting the whole pipeline drains, so input is taken
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked while result register empty");

  // right after reset, with no input transfer, no result comes out
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n, 1) && !(in_tvalid && in_tready) |=> !out_tvalid)
    else $error("result without an input transfer");

  // configuration writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind tcp_rto_estimator_core tcprto_checker u_tcprto_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

// File: verif/tb.sv
// tb: self-checking testbench for tcp_rto_estimator_core
// drives rtt samples and register writes, predicts rto, srtt and rttvar per sample
// depends on tcprto_pkg and tcp_rto_estimator_core
module tb;

  localparam int PRIM_W     = tcprto_pkg::PRIM_W;
  localparam int FALL_W     = tcprto_pkg::FALL_W;
  localparam int TICK_W     = tcprto_pkg::TICK_W;
  localparam int STATE_W    = tcprto_pkg::STATE_W;
  localparam int SHIFT_W    = tcprto_pkg::SHIFT_W;
  localparam int IN_DATA_W  = tcprto_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = tcprto_pkg::OUT_DATA_W;
  localparam int CFG_DATA_W = tcprto_pkg::CFG_DATA_W;

  localparam int TIME_BITS   = 24;
  localparam int FRAC_BITS   = 8;
  localparam int LATENCY     = 2;   // result passes the state and rto registers after the input transfer
  localparam int HOLD_CYCLES = 80;  // long receiver hold-off under pressure
  localparam int PHASE_ITEMS = 200;
  localparam logic [63:0] SAT32    = 64'hFFFF_FFFF;
  localparam logic [63:0] TIME_MAX = (64'd1 << TIME_BITS) - 64'd1;

  typedef struct {
    logic [TICK_W-1:0]  rto;
    logic [STATE_W-1:0] srtt;
    logic [STATE_W-1:0] rttvar;
  } rto_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  tcprto_pkg::cfg_reg_t  cfg_index  = tcprto_pkg::REG_ALPHA_SHIFT;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // predictor copy of the registers and the averaging state
  logic [SHIFT_W-1:0] alpha_sh    = tcprto_pkg::ALPHA_SHIFT_RST;
  logic [SHIFT_W-1:0] beta_sh     = tcprto_pkg::BETA_SHIFT_RST;
  logic [TICK_W-1:0]  gran_ticks  = tcprto_pkg::CLOCK_GRAN_RST;
  logic [TICK_W-1:0]  limit_ticks = tcprto_pkg::RTO_LIMIT_RST;
  logic [63:0]        srtt_fx     = 64'(tcprto_pkg::STATE_INIT_TICKS) << FRAC_BITS;
  logic [63:0]        rttvar_fx   = 64'(tcprto_pkg::STATE_INIT_TICKS) << FRAC_BITS;

  rto_result_t rto_expect_q[$];
  int          errors     = 0;
  int          idle_pct   = 0;   // chance the sender skips a cycle
  int          stall_pct  = 0;   // chance the receiver drops tready
  int          hold_req   = 0;   // bumped by the test to ask for a hold-off
  int          hold_ack   = 0;
  int          hold_left  = 0;

  always #5 clk = ~clk;

  tcp_rto_estimator_core #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // move cur toward tgt by |tgt - cur| >> sh, truncating toward cur
  function automatic logic [63:0] ewma_step(logic [63:0] cur, logic [63:0] tgt,
                                            logic [SHIFT_W-1:0] sh);
    if (tgt >= cur) return cur + ((tgt - cur) >> sh);
    return cur - ((cur - tgt) >> sh);
  endfunction

  // one sample through the estimator: updates srtt_fx/rttvar_fx, returns the result
  function automatic rto_result_t predict_rto(logic [PRIM_W-1:0] prim, logic [FALL_W-1:0] fall);
    logic [63:0] ticks, meas, srtt, dev, dev_avg, g, four, sum;
    rto_result_t r;
    // karn's rule: a negative primary sample falls back to the alternative
    ticks = prim[PRIM_W-1] ? 64'(fall) : 64'(prim[PRIM_W-2:0]);
    if (ticks > TIME_MAX) ticks = TIME_MAX;
    meas = ticks << FRAC_BITS;
    if (meas > SAT32) meas = SAT32;
    srtt = ewma_step(srtt_fx, meas, alpha_sh);
    // deviation measured against the freshly updated average
    dev = (srtt >= meas) ? srtt - meas : meas - srtt;
    dev_avg = ewma_step(rttvar_fx, dev, beta_sh);
    if (srtt > SAT32) srtt = SAT32;
    if (dev_avg > SAT32) dev_avg = SAT32;
    srtt_fx = srtt;
    rttvar_fx = dev_avg;
    g = 64'(gran_ticks) << FRAC_BITS;
    four = dev_avg << 2;
    sum = srtt + ((g > four) ? g : four);
    // round up to whole ticks, then clamp
    sum = (sum + ((64'd1 << FRAC_BITS) - 64'd1)) >> FRAC_BITS;
    if (sum > 64'(limit_ticks)) sum = 64'(limit_ticks);
    r.rto = sum[TICK_W-1:0];
    r.srtt = srtt[STATE_W-1:0];
    r.rttvar = dev_avg[STATE_W-1:0];
    return r;
  endfunction

  // one sample transfer; the prediction is queued at the accepting edge
  task automatic send_sample(input logic signed [PRIM_W-1:0] prim,
                             input logic [FALL_W-1:0] fall);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-PRIM_W-FALL_W){1'b0}}, fall, prim};
    do @(posedge clk); while (!in_tready);
    rto_expect_q.push_back(predict_rto(prim, fall));
  endtask

  // stop offering and wait until every result is back, plus the pipeline depth
  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (rto_expect_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // one register write; the caller drops cfg_valid after the last one
  task automatic write_reg(input tcprto_pkg::cfg_reg_t idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tcprto_pkg::REG_ALPHA_SHIFT: alpha_sh    = val[SHIFT_W-1:0];
      tcprto_pkg::REG_BETA_SHIFT:  beta_sh     = val[SHIFT_W-1:0];
      tcprto_pkg::REG_CLOCK_GRAN:  gran_ticks  = val[TICK_W-1:0];
      tcprto_pkg::REG_RTO_LIMIT:   limit_ticks = val[TICK_W-1:0];
      default: ;
    endcase
  endtask

  // all four registers, only once the block has gone quiet
  task automatic set_config(input logic [SHIFT_W-1:0] a, input logic [SHIFT_W-1:0] b,
                            input logic [TICK_W-1:0] g, input logic [TICK_W-1:0] l);
    drain_pipe();
    // upper data bits on the shift registers are don't-care, so fill them randomly
    write_reg(tcprto_pkg::REG_ALPHA_SHIFT, {21'($urandom), a});
    write_reg(tcprto_pkg::REG_BETA_SHIFT,  {21'($urandom), b});
    write_reg(tcprto_pkg::REG_CLOCK_GRAN,  g);
    write_reg(tcprto_pkg::REG_RTO_LIMIT,   l);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config();
    logic [TICK_W-1:0] g, l;
    case ($urandom_range(3))
      0:       g = '0;
      1:       g = 24'd1;
      2:       g = 24'($urandom_range(50));
      default: g = 24'($urandom);
    endcase
    case ($urandom_range(5))
      0:       l = 24'hFF_FFFF;
      1:       l = 24'($urandom);
      2:       l = 24'($urandom_range(3));
      default: l = 24'($urandom_range(4, 3000));
    endcase
    set_config(3'($urandom_range(7)), 3'($urandom_range(7)), g, l);
  endtask

  // mostly realistic rtts so the averages settle, with full-range and invalid mixed in
  task automatic random_sample(output logic signed [PRIM_W-1:0] prim,
                               output logic [FALL_W-1:0] fall);
    int unsigned pick;
    pick = $urandom_range(99);
    fall = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(400));
    if (pick < 60)
      prim = 25'($urandom_range(400));
    else if (pick < 75)
      prim = {1'b0, 24'($urandom)};
    else if (pick < 85)
      prim = {1'b1, 24'($urandom)};
    else
      prim = -25'sd1 - 25'($urandom_range(15));
  endtask

  task automatic run_random(input int n);
    logic signed [PRIM_W-1:0] prim;
    logic [FALL_W-1:0]        fall;
    repeat (n) begin
      random_sample(prim, fall);
      send_sample(prim, fall);
    end
  endtask

  // --- tests ---

  // register defaults straight after reset, sample extremes and invalid primaries
  task automatic test_reset_defaults();
    send_sample(25'sd0, 24'd0);
    send_sample(25'sd16777215, 24'd0);
    send_sample(-25'sd1, 24'd0);
    send_sample(-25'sd16777216, 24'hFF_FFFF);
    send_sample(25'sd5, 24'hFF_FFFF);
    send_sample(-25'sd1, 24'd7);
  endtask

  // shift, granularity and limit extremes
  task automatic test_register_extremes();
    // no smoothing: state jumps straight to the sample, zero granularity
    set_config(3'd0, 3'd0, 24'd0, 24'hFF_FFFF);
    send_sample(25'sd100, 24'd0);
    send_sample(25'sd100, 24'd0);
    send_sample(25'sd16777215, 24'd0);
    send_sample(25'sd0, 24'd0);
    send_sample(-25'sd5, 24'hFF_FFFF);
    // heaviest smoothing, granularity at maximum, limit of zero
    set_config(3'd7, 3'd7, 24'hFF_FFFF, 24'd0);
    send_sample(25'sd1000, 24'd0);
    send_sample(25'sd0, 24'd0);
    send_sample(-25'sd16777216, 24'd12345);
    // granularity dominates and the sum runs past the limit
    set_config(3'd1, 3'd4, 24'hFF_FFFF, 24'hFF_FFFF);
    send_sample(25'sd10, 24'd0);
    send_sample(25'sd16777215, 24'd0);
    send_sample(-25'sd1, 24'hFF_FFFF);
    // moderate settings, rounding up to whole ticks
    set_config(3'd5, 3'd3, 24'd2, 24'd1000);
    send_sample(25'sd50, 24'd0);
    send_sample(-25'sd2, 24'd60);
    send_sample(25'sd3, 24'd0);
  endtask

  // random samples under each idling mix, two settings per mix
  task automatic test_idle_phases();
    int phase_idle[4]  = '{0, 70, 0, 30};
    int phase_stall[4] = '{0, 0, 70, 30};
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 2; k++) begin
        random_config();
        idle_pct = phase_idle[p];
        stall_pct <= phase_stall[p];
        run_random(PHASE_ITEMS);
      end
    end
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    drain_pipe();
    idle_pct = 0;
    stall_pct <= 0;
    hold_req <= hold_req + 1;
    run_random(40);
    // sender pauses until every result has come back
    drain_pipe();
    run_random(10);
  endtask

  // receiver: random stalls, or a counted hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_ack   <= hold_req;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker: each transfer against the oldest prediction
  always @(posedge clk) begin
    rto_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (rto_expect_q.size() == 0) begin
        $error("result transfer with no prediction waiting: tdata %h", out_tdata);
        errors++;
      end else begin
        want = rto_expect_q.pop_front();
        if (out_tdata[23:0] !== want.rto) begin
          $error("rto_value: expected %0d, got %0d", want.rto, out_tdata[23:0]);
          errors++;
        end
        if (out_tdata[55:24] !== want.srtt) begin
          $error("smoothed_rtt: expected %h, got %h", want.srtt, out_tdata[55:24]);
          errors++;
        end
        if (out_tdata[87:56] !== want.rttvar) begin
          $error("rtt_deviation: expected %h, got %h", want.rttvar, out_tdata[87:56]);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_idle_phases();
    test_backpressure();
    drain_pipe();
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard, well beyond the slowest legal run
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: tcp_rto_estimator_core.f
rtl/core/tcprto_pkg.sv
rtl/core/tcp_rto_estimator_core.sv
rtl/core/tcprto_checker.sv
verif/tb.sv
